// File: rtl/core/sfm_pkg.sv
// ----------------------------------------------------------------------------
// sfm_pkg: shared types and constants for the substring first-match search
// Item and result layouts, action and error codes, default size limits.
// ----------------------------------------------------------------------------
package sfm_pkg;

  localparam int unsigned NEEDLE_MAX_DEF   = 16;
  localparam int unsigned HAYSTACK_MAX_DEF = 65536;
  localparam int unsigned MATCH_W          = 16;

  localparam logic ACT_NEEDLE = 1'b0;
  localparam logic ACT_HAY    = 1'b1;

  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_NEEDLE_LONG = 2'd1;
  localparam logic [1:0] ERR_HAY_LONG    = 2'd2;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [MATCH_W-1:0] match_index;
    logic [1:0]         error_code;
  } res_t;

endpackage

// File: rtl/core/sfm_if.sv
// ----------------------------------------------------------------------------
// sfm_in_if / sfm_out_if: valid/ready channels of the first-match search
// Input channel carries needle or haystack bytes, output channel the result.
// ----------------------------------------------------------------------------
interface sfm_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, action, data_byte, is_last, input ready);
  modport sink   (input valid, action, data_byte, is_last, output ready);
endinterface

interface sfm_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [15:0] match_index;
  logic [1:0]  error_code;

  modport source (output valid, found, match_index, error_code, input ready);
  modport sink   (input valid, found, match_index, error_code, output ready);
endinterface

// File: rtl/core/sfm_window_cmp.sv
// ----------------------------------------------------------------------------
// sfm_window_cmp: parallel compare of the byte window with the needle
// Window entry 0 is the newest byte; needle entry 0 the first needle byte.
// ----------------------------------------------------------------------------
module sfm_window_cmp #(
  parameter int unsigned NEEDLE_MAX = 16,
  parameter int unsigned CNT_W      = 5
) (
  input  logic [7:0]       needle_bytes [NEEDLE_MAX],
  input  logic [7:0]       window_bytes [NEEDLE_MAX],
  input  logic [CNT_W-1:0] needle_count,
  output logic             window_hit
);

  // needle byte j lines up with window byte count-1-j
  always_comb begin
    window_hit = 1'b1;
    for (int j = 0; j < NEEDLE_MAX; j++) begin
      for (int k = 0; k < NEEDLE_MAX; k++) begin
        if ((j + k + 1 == int'(needle_count)) && (needle_bytes[j] != window_bytes[k])) begin
          window_hit = 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/core/sfm_engine.sv
// ----------------------------------------------------------------------------
// sfm_engine: needle store, byte window and first-hit tracking
// Updates all search state for one item per fire and forms the result.
// ----------------------------------------------------------------------------
module sfm_engine #(
  parameter int unsigned NEEDLE_MAX   = 16,
  parameter int unsigned HAYSTACK_MAX = 65536
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  sfm_pkg::item_t item,
  output logic          res_valid,
  output sfm_pkg::res_t res
);
  import sfm_pkg::*;

  localparam int unsigned CNT_W  = $clog2(NEEDLE_MAX + 1);
  localparam int unsigned POS_W  = $clog2(HAYSTACK_MAX + 2);
  localparam int unsigned WIDE_A = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int unsigned WIDE_W = (WIDE_A > MATCH_W) ? WIDE_A : MATCH_W;

  logic [7:0]         needle_r [NEEDLE_MAX];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               closed_r, closed_nxt;
  logic               too_long_r, too_long_nxt;
  logic [7:0]         wnd_r [NEEDLE_MAX];
  logic [7:0]         wnd_nxt [NEEDLE_MAX];
  logic [7:0]         wnd_sh [NEEDLE_MAX];
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               hit_r, hit_nxt;
  logic [MATCH_W-1:0] off_r, off_nxt;

  logic               needle_wr;
  logic [CNT_W-1:0]   wr_idx;
  logic               window_hit;
  logic [POS_W-1:0]   pos_inc;
  logic [WIDE_W-1:0]  off_wide;
  logic [1:0]         err;

  always_comb begin
    wnd_sh[0] = item.data_byte;
    for (int k = 1; k < NEEDLE_MAX; k++) begin
      wnd_sh[k] = wnd_r[k-1];
    end
  end

  assign pos_inc  = pos_r + POS_W'(1);
  assign off_wide = WIDE_W'(pos_inc) - WIDE_W'(cnt_r);

  sfm_window_cmp #(
    .NEEDLE_MAX (NEEDLE_MAX),
    .CNT_W      (CNT_W)
  ) u_cmp (
    .needle_bytes (needle_r),
    .window_bytes (wnd_sh),
    .needle_count (cnt_r),
    .window_hit   (window_hit)
  );

  always_comb begin
    cnt_nxt      = cnt_r;
    closed_nxt   = closed_r;
    too_long_nxt = too_long_r;
    wnd_nxt      = wnd_r;
    pos_nxt      = pos_r;
    hit_nxt      = hit_r;
    off_nxt      = off_r;
    needle_wr    = 1'b0;
    wr_idx       = cnt_r;
    res_valid    = 1'b0;
    err          = ERR_NONE;
    res          = '0;

    if (item.action == ACT_NEEDLE) begin
      // a needle byte after a closed needle starts a fresh needle
      if (closed_r) begin
        wr_idx       = '0;
        too_long_nxt = 1'b0;
        for (int k = 0; k < NEEDLE_MAX; k++) begin
          wnd_nxt[k] = '0;
        end
        pos_nxt = '0;
        hit_nxt = 1'b0;
        off_nxt = '0;
      end
      if (WIDE_W'(wr_idx) < WIDE_W'(NEEDLE_MAX)) begin
        needle_wr = 1'b1;
        cnt_nxt   = wr_idx + CNT_W'(1);
      end else begin
        cnt_nxt      = wr_idx;
        too_long_nxt = 1'b1;
      end
      closed_nxt = item.is_last;
    end else begin
      closed_nxt = 1'b1;
      if (WIDE_W'(pos_r) < WIDE_W'(HAYSTACK_MAX)) begin
        wnd_nxt = wnd_sh;
        pos_nxt = pos_inc;
        if (!hit_r && !too_long_r && (cnt_r != '0) &&
            (WIDE_W'(pos_inc) >= WIDE_W'(cnt_r)) && window_hit) begin
          hit_nxt = 1'b1;
          off_nxt = off_wide[MATCH_W-1:0];
        end
      end else begin
        pos_nxt = POS_W'(HAYSTACK_MAX + 1);
      end

      if (item.is_last) begin
        res_valid = 1'b1;
        if (too_long_r) begin
          err = ERR_NEEDLE_LONG;
        end else if (WIDE_W'(pos_nxt) > WIDE_W'(HAYSTACK_MAX)) begin
          err = ERR_HAY_LONG;
        end
        res.error_code = err;
        if (err == ERR_NONE && hit_nxt) begin
          res.found       = 1'b1;
          res.match_index = off_nxt;
        end
        // drop haystack state, keep the needle
        for (int k = 0; k < NEEDLE_MAX; k++) begin
          wnd_nxt[k] = '0;
        end
        pos_nxt = '0;
        hit_nxt = 1'b0;
        off_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && needle_wr) begin
      for (int i = 0; i < NEEDLE_MAX; i++) begin
        if (wr_idx == CNT_W'(i)) begin
          needle_r[i] <= item.data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      closed_r   <= 1'b0;
      too_long_r <= 1'b0;
      for (int k = 0; k < NEEDLE_MAX; k++) begin
        wnd_r[k] <= '0;
      end
      pos_r <= '0;
      hit_r <= 1'b0;
      off_r <= '0;
    end else if (fire) begin
      cnt_r      <= cnt_nxt;
      closed_r   <= closed_nxt;
      too_long_r <= too_long_nxt;
      wnd_r      <= wnd_nxt;
      pos_r      <= pos_nxt;
      hit_r      <= hit_nxt;
      off_r      <= off_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    WIDE_W'(cnt_r) <= WIDE_W'(NEEDLE_MAX))
    else $error("needle count beyond limit");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.action == ACT_HAY && item.is_last |=> pos_r == '0 && !hit_r)
    else $error("haystack state not cleared at end of haystack");

  a_hit_needs_needle: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r |-> cnt_r != '0 && !too_long_r)
    else $error("hit recorded without a valid needle");

endmodule

// File: rtl/core/substring_first_match.sv
// ----------------------------------------------------------------------------
// substring_first_match: first offset of a needle in a streamed haystack
// Input register, single-pass search engine, registered result channel.
// ----------------------------------------------------------------------------
// A result passes through the input register, then the result register, before
//   it is valid on out_ch; a full result register holds it back.
// Throughput: one byte per cycle unless a result waits on a full result register; the window compare is combinational.
// Reset (synchronous, rst_n low): empties the needle, window and hit state
//   and drops any item held in the input or result register.
module substring_first_match #(
  parameter int unsigned NEEDLE_MAX   = sfm_pkg::NEEDLE_MAX_DEF,
  parameter int unsigned HAYSTACK_MAX = sfm_pkg::HAYSTACK_MAX_DEF
) (
  input logic      clk,
  input logic      rst_n,
  sfm_in_if.sink   in_ch,
  sfm_out_if.source out_ch
);
  import sfm_pkg::*;

  logic  s1_valid_r;
  item_t item_r;
  logic  out_valid_r;
  res_t  out_r;
  logic  eng_res_valid;
  res_t  eng_res;
  logic  out_free;
  logic  advance;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign advance      = s1_valid_r && (!eng_res_valid || out_free);
  assign in_ch.ready  = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.action    <= in_ch.action;
      item_r.data_byte <= in_ch.data_byte;
      item_r.is_last   <= in_ch.is_last;
    end
  end

  sfm_engine #(
    .NEEDLE_MAX   (NEEDLE_MAX),
    .HAYSTACK_MAX (HAYSTACK_MAX)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (item_r),
    .res_valid (eng_res_valid),
    .res       (eng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && eng_res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && eng_res_valid) begin
      out_r <= eng_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_r.found;
  assign out_ch.match_index = out_r.match_index;
  assign out_ch.error_code  = out_r.error_code;

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance && eng_res_valid))
    else $error("result appeared without an engine result");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(item_r))
    else $error("stalled input item lost or changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    advance && eng_res_valid |-> out_free)
    else $error("result register overwritten while full");

endmodule

// File: test/sfm_match_checker.sv
// ----------------------------------------------------------------------------
// sfm_match_checker: result predictor and scoreboard for substring_first_match
// Watches both channels. Every accepted item goes through a cycle-free model of
// the search; the results it predicts are queued and compared, field by field
// and in order, with the results the block delivers.
// ----------------------------------------------------------------------------
module sfm_match_checker #(
  parameter int unsigned NEEDLE_MAX   = sfm_pkg::NEEDLE_MAX_DEF,
  parameter int unsigned HAYSTACK_MAX = sfm_pkg::HAYSTACK_MAX_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sfm_in_if    in_mon,
  sfm_out_if   out_mon,
  output int   fail_count,
  output int   pending
);
  import sfm_pkg::*;

  logic [7:0]  needle_mem [NEEDLE_MAX];
  int unsigned needle_len;
  bit          needle_done;
  bit          needle_over;
  logic [7:0]  tail_bytes [NEEDLE_MAX];
  int unsigned hay_pos;
  bit          hit;
  int unsigned hit_at;

  res_t        pending_matches [$];

  function automatic void clear_haystack();
    for (int i = 0; i < NEEDLE_MAX; i++) tail_bytes[i] = 8'h00;
    hay_pos = 0;
    hit     = 1'b0;
    hit_at  = 0;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Advance the search by one item; emits is set when the item ends a haystack.
  task automatic search_step(input item_t it, output bit emits, output res_t r);
    bit          same;
    logic [1:0]  err;
    emits = 1'b0;
    r     = '0;
    if (it.action == ACT_NEEDLE) begin
      if (needle_done) begin
        needle_done = 1'b0;
        needle_len  = 0;
        needle_over = 1'b0;
        clear_haystack();
      end
      if (needle_len < NEEDLE_MAX) begin
        needle_mem[needle_len] = it.data_byte;
        needle_len++;
      end else begin
        needle_over = 1'b1;
      end
      if (it.is_last) needle_done = 1'b1;
    end else begin
      needle_done = 1'b1;
      if (hay_pos < HAYSTACK_MAX) begin
        for (int k = NEEDLE_MAX - 1; k > 0; k--) tail_bytes[k] = tail_bytes[k-1];
        tail_bytes[0] = it.data_byte;
        hay_pos++;
        if (!hit && !needle_over && needle_len > 0 && hay_pos >= needle_len) begin
          // newest byte sits at index 0, so the needle runs backward in the window
          same = 1'b1;
          for (int j = 0; j < needle_len; j++)
            if (needle_mem[j] != tail_bytes[needle_len-1-j]) same = 1'b0;
          if (same) begin
            hit    = 1'b1;
            hit_at = hay_pos - needle_len;
          end
        end
      end else begin
        hay_pos = HAYSTACK_MAX + 1;
      end
      if (it.is_last) begin
        if (needle_over)                err = ERR_NEEDLE_LONG;
        else if (hay_pos > HAYSTACK_MAX) err = ERR_HAY_LONG;
        else                            err = ERR_NONE;
        r.error_code = err;
        if (err == ERR_NONE && hit) begin
          r.found       = 1'b1;
          r.match_index = hit_at[MATCH_W-1:0];
        end
        emits = 1'b1;
        clear_haystack();
      end
    end
  endtask

  always @(posedge clk) begin : watch
    item_t it;
    res_t  got;
    res_t  want;
    res_t  r;
    bit    emits;
    if (!rst_n) begin
      needle_len  = 0;
      needle_done = 1'b0;
      needle_over = 1'b0;
      clear_haystack();
      pending_matches.delete();
      fail_count  = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.found       = out_mon.found;
        got.match_index = out_mon.match_index;
        got.error_code  = out_mon.error_code;
        if (pending_matches.size() == 0) begin
          report_mismatch($sformatf("result with no haystack pending: found %0b index %0d err %0d",
                                    got.found, got.match_index, got.error_code));
        end else begin
          want = pending_matches.pop_front();
          if (got.found !== want.found)
            report_mismatch($sformatf("found: got %0b, expected %0b", got.found, want.found));
          if (got.match_index !== want.match_index)
            report_mismatch($sformatf("match_index: got %0d, expected %0d",
                                      got.match_index, want.match_index));
          if (got.error_code !== want.error_code)
            report_mismatch($sformatf("error_code: got %0d, expected %0d",
                                      got.error_code, want.error_code));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        it.action    = in_mon.action;
        it.data_byte = in_mon.data_byte;
        it.is_last   = in_mon.is_last;
        search_step(it, emits, r);
        if (emits) pending_matches.push_back(r);
      end
    end
    pending <= pending_matches.size();
  end

endmodule

// File: test/substring_first_match_tb.sv
// ----------------------------------------------------------------------------
// substring_first_match_tb: stimulus and verdict for the first-match search
// Directed needles and haystacks, then random search sessions under four
// idling mixes and a long output hold-off.
// A side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module substring_first_match_tb;
  import sfm_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1650;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 2000;

  logic clk;
  logic rst_n;

  sfm_in_if  in_ch ();
  sfm_out_if out_ch ();

  int          fail_count;
  int          pending;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_requests;
  int unsigned items_sent;

  logic [7:0]  alphabet [4];
  int unsigned alphabet_size;
  bit          wide_bytes;

  substring_first_match i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sfm_match_checker #(
    .NEEDLE_MAX   (NEEDLE_MAX_DEF),
    .HAYSTACK_MAX (HAYSTACK_MAX_DEF)
  ) i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned served;
    hold_left    = 0;
    served       = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != served) begin
        served    = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_byte(input logic act, input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_ch.valid     = 1'b1;
    in_ch.action    = act;
    in_ch.data_byte = b;
    in_ch.is_last   = last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
    items_sent++;
  endtask

  task automatic send_run(input logic act, input logic [7:0] bytes [$], input bit close);
    for (int i = 0; i < bytes.size(); i++)
      push_byte(act, bytes[i], close && (i == bytes.size() - 1));
  endtask

  task automatic drain_results();
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    if (wide_bytes) return 8'($urandom);
    return alphabet[$urandom_range(alphabet_size - 1)];
  endfunction

  // One search session: mostly a needle and a few haystacks, some built to hit it,
  // sometimes an open needle, an abandoned haystack or plain noise.
  task automatic random_session();
    logic [7:0]  needle [$];
    logic [7:0]  hay [$];
    int unsigned nlen;
    int unsigned hlen;
    int unsigned pos;
    int unsigned r;
    alphabet_size = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) alphabet[i] = 8'($urandom);
    wide_bytes = ($urandom_range(3) == 0);
    if ($urandom_range(99) < 85) begin
      r = $urandom_range(99);
      if (r < 6)       nlen = $urandom_range(NEEDLE_MAX_DEF + 1, NEEDLE_MAX_DEF + 4);
      else if (r < 40) nlen = $urandom_range(1, 2);
      else if (r < 80) nlen = $urandom_range(3, 5);
      else             nlen = $urandom_range(6, NEEDLE_MAX_DEF);
      for (int i = 0; i < nlen; i++) needle.push_back(pick_byte());
      send_run(ACT_NEEDLE, needle, 1'b1);
      repeat ($urandom_range(1, 3)) begin
        hlen = ($urandom_range(9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
        hay.delete();
        for (int i = 0; i < hlen; i++) hay.push_back(pick_byte());
        if ($urandom_range(1) == 1 && nlen <= hlen) begin
          pos = $urandom_range(0, hlen - nlen);
          for (int i = 0; i < nlen; i++) hay[pos + i] = needle[i];
        end
        send_run(ACT_HAY, hay, 1'b1);
      end
    end else begin
      case ($urandom_range(2))
        0: begin
          // haystack arrives while the needle is still open
          for (int i = 0; i < $urandom_range(1, 3); i++) needle.push_back(pick_byte());
          send_run(ACT_NEEDLE, needle, 1'b0);
          for (int i = 0; i < $urandom_range(1, 8); i++) hay.push_back(pick_byte());
          send_run(ACT_HAY, hay, 1'b1);
        end
        1: begin
          // haystack left unfinished; the next needle abandons it
          for (int i = 0; i < $urandom_range(1, 6); i++) hay.push_back(pick_byte());
          send_run(ACT_HAY, hay, 1'b0);
        end
        default: begin
          repeat ($urandom_range(1, 6))
            push_byte(1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)));
        end
      endcase
    end
  endtask

  initial begin : stimulus
    int unsigned goal;
    int unsigned base;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_NEEDLE;
    in_ch.data_byte = 8'h00;
    in_ch.is_last   = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_requests   = 0;
    items_sent      = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty needle right after reset
    send_run(ACT_HAY, '{8'h41}, 1'b1);
    // extreme bytes, hit at offset 1
    send_run(ACT_NEEDLE, '{8'h00, 8'hFF}, 1'b1);
    send_run(ACT_HAY, '{8'h11, 8'h00, 8'hFF, 8'h00, 8'hFF}, 1'b1);
    // haystack while the needle is open closes it
    send_run(ACT_NEEDLE, '{8'h80}, 1'b0);
    send_run(ACT_HAY, '{8'h80}, 1'b1);
    // new needle abandons a haystack with a hit already in it
    send_run(ACT_HAY, '{8'h80}, 1'b0);
    send_run(ACT_NEEDLE, '{8'h7F}, 1'b1);
    send_run(ACT_HAY, '{8'h80}, 1'b1);
    // needle longer than haystack, then the same needle on a longer haystack
    send_run(ACT_NEEDLE, '{8'h01, 8'h02, 8'h03}, 1'b1);
    send_run(ACT_HAY, '{8'h01, 8'h02}, 1'b1);
    send_run(ACT_HAY, '{8'h55, 8'h01, 8'h02, 8'h03}, 1'b1);
    drain_results();

    base = items_sent;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 47; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      if (p == 0) begin
        // hold the output long enough to back the block up into its input
        hold_requests++;
        @(negedge clk);
        send_run(ACT_NEEDLE, '{8'h5A}, 1'b1);
        repeat (40) push_byte(ACT_HAY, $urandom_range(1) ? 8'h5A : 8'h3C, 1'b1);
      end
      goal = base + (p + 1) * RANDOM_ITEMS / 4;
      while (items_sent < goal) random_session();
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
